// File: hw/rtl/lkvt_pkg.sv
`default_nettype none

package lkvt_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;

    localparam int S_DATA_BITS = MODE_W + KEY_BITS + VALUE_BITS;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = STATUS_W + VALUE_BITS + CNT_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_UPDATED   = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_REMOVED   = 3'd4,
        STAT_FULL      = 3'd5
    } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/lkvt_ram.sv
`default_nettype none

module lkvt_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    // Simple dual-port storage with a registered read.
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/linear_key_value_table_core.sv
`default_nettype none

// Key/value table kept as a compacted, unordered array of CAPACITY pairs in two
// block memories (keys and values) with a live entry count. Each input transfer
// carries a mode (insert, search, remove), a key and a value, and produces
// exactly one result transfer with a status, the value read by a found search
// (zero otherwise) and the entry count after the operation. A request scans
// the live entries one per cycle through the memories' single read port, up to
// a match or the end of the table. A remove then moves every later pair down
// one place, one pair per cycle, using the read port and the write port
// together. Since the scan stops at the match and the move starts right behind
// it, scan and move together never cover more than the live entries. An insert
// of a new key into a full table stores nothing and reports table full. One
// request is worked on at a time; a finished result sits in the output
// register so the next request can be taken while the result waits for the
// downstream side.
module linear_key_value_table_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata, from bit 0 up: mode, lookup_key, entry_value, zero fill
    input  wire logic [lkvt_pkg::S_DATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata, from bit 0 up: status, read_value, entry_count, zero fill
    output logic      [lkvt_pkg::M_DATA_W-1:0] m_tdata
);

    import lkvt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_SHIFT,
        S_RESP
    } state_t;

    state_t state_reg;

    // Request held for the duration of the operation.
    logic [MODE_W-1:0]     mode_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;

    logic [CNT_W-1:0]      live_count_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      mv_idx_reg;

    status_t               status_reg;
    logic [VALUE_BITS-1:0] rd_value_reg;

    // Output register.
    logic                  m_tvalid_reg;
    status_t               m_status_reg;
    logic [VALUE_BITS-1:0] m_value_reg;
    logic [CNT_W-1:0]      m_count_reg;

    // Memory ports.
    logic                  key_we;
    logic                  val_we;
    logic [IDX_W-1:0]      wr_addr;
    logic [KEY_BITS-1:0]   key_wdata;
    logic [VALUE_BITS-1:0] val_wdata;
    logic [IDX_W-1:0]      rd_addr;
    logic [KEY_BITS-1:0]   key_q;
    logic [VALUE_BITS-1:0] val_q;

    logic                  s_fire;
    logic                  out_free;
    logic [CNT_W-1:0]      cmp_idx_inc;
    logic [CNT_W-1:0]      slot_inc;
    logic [CNT_W-1:0]      mv_idx_inc;
    logic                  key_hit;

    assign s_tready    = (state_reg == S_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign cmp_idx_inc = CNT_W'(cmp_idx_reg) + CNT_W'(1);
    assign slot_inc    = CNT_W'(slot_reg) + CNT_W'(1);
    assign mv_idx_inc  = CNT_W'(mv_idx_reg) + CNT_W'(1);
    assign key_hit     = (key_q == key_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({m_count_reg, m_value_reg, m_status_reg});

    lkvt_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (key_wdata),
        .raddr (rd_addr),
        .rdata (key_q)
    );

    lkvt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (wr_addr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_q)
    );

    // Memory access steering. The read address always points at the entry whose
    // data the state machine will look at in the next cycle.
    always_comb begin
        key_we    = 1'b0;
        val_we    = 1'b0;
        wr_addr   = slot_reg;
        key_wdata = key_reg;
        val_wdata = val_reg;
        rd_addr   = '0;
        unique case (state_reg)
            S_IDLE: begin
                rd_addr = '0;
            end
            S_SCAN: begin
                rd_addr = cmp_idx_inc[IDX_W-1:0];
            end
            S_ACT: begin
                rd_addr = slot_inc[IDX_W-1:0];
                if (mode_reg == MODE_INSERT) begin
                    if (found_reg) begin
                        val_we  = 1'b1;
                        wr_addr = slot_reg;
                    end else if (live_count_reg < CNT_W'(CAPACITY)) begin
                        key_we  = 1'b1;
                        val_we  = 1'b1;
                        wr_addr = live_count_reg[IDX_W-1:0];
                    end
                end
            end
            S_SHIFT: begin
                // Move the pair read last cycle down one place while fetching
                // the next one.
                key_we    = 1'b1;
                val_we    = 1'b1;
                wr_addr   = mv_idx_reg - IDX_W'(1);
                key_wdata = key_q;
                val_wdata = val_q;
                rd_addr   = mv_idx_inc[IDX_W-1:0];
            end
            S_RESP: begin
                rd_addr = '0;
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            live_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        mode_reg     <= s_tdata[MODE_W-1:0];
                        key_reg      <= s_tdata[MODE_W +: KEY_BITS];
                        val_reg      <= s_tdata[MODE_W + KEY_BITS +: VALUE_BITS];
                        cmp_idx_reg  <= '0;
                        found_reg    <= 1'b0;
                        rd_value_reg <= '0;
                        // An empty table has nothing to compare against.
                        state_reg    <= (live_count_reg == '0) ? S_ACT : S_SCAN;
                    end
                end

                S_SCAN: begin
                    if (key_hit) begin
                        found_reg    <= 1'b1;
                        slot_reg     <= cmp_idx_reg;
                        rd_value_reg <= val_q;
                        state_reg    <= S_ACT;
                    end else if (cmp_idx_inc >= live_count_reg) begin
                        state_reg <= S_ACT;
                    end else begin
                        cmp_idx_reg <= cmp_idx_inc[IDX_W-1:0];
                    end
                end

                S_ACT: begin
                    state_reg    <= S_RESP;
                    status_reg   <= STAT_NOT_FOUND;
                    rd_value_reg <= '0;
                    unique case (mode_reg)
                        MODE_INSERT: begin
                            if (found_reg) begin
                                status_reg <= STAT_UPDATED;
                            end else if (live_count_reg < CNT_W'(CAPACITY)) begin
                                status_reg     <= STAT_INSERTED;
                                live_count_reg <= live_count_reg + CNT_W'(1);
                            end else begin
                                status_reg <= STAT_FULL;
                            end
                        end
                        MODE_SEARCH: begin
                            if (found_reg) begin
                                status_reg   <= STAT_FOUND;
                                rd_value_reg <= rd_value_reg;
                            end
                        end
                        MODE_REMOVE: begin
                            if (found_reg) begin
                                status_reg <= STAT_REMOVED;
                                if (slot_inc < live_count_reg) begin
                                    // Pairs behind the removed one close the gap.
                                    mv_idx_reg <= slot_inc[IDX_W-1:0];
                                    state_reg  <= S_SHIFT;
                                end else begin
                                    live_count_reg <= live_count_reg - CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                            status_reg <= STAT_NOT_FOUND;
                        end
                    endcase
                end

                S_SHIFT: begin
                    if (mv_idx_inc < live_count_reg) begin
                        mv_idx_reg <= mv_idx_inc[IDX_W-1:0];
                    end else begin
                        live_count_reg <= live_count_reg - CNT_W'(1);
                        state_reg      <= S_RESP;
                    end
                end

                S_RESP: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= status_reg;
                        m_value_reg  <= rd_value_reg;
                        m_count_reg  <= live_count_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lkvt_pkg::*;

    // Mode 3 has no name in the package. The block must answer it as a miss
    // and leave the table alone.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // A remove of the first entry in a full table scans one entry and then
    // moves every later pair down, so no request takes longer.
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;

    // At most this many mismatch lines are printed. Every mismatch is still counted.
    localparam int PRINT_LIMIT = 40;

    // One result transfer as the block should produce it.
    typedef struct packed {
        status_t               status;
        logic [VALUE_BITS-1:0] read_value;
        logic [CNT_W-1:0]      entry_count;
    } reply_t;

    // The scoreboard keeps its own copy of the table and predicts the reply
    // for each request when that request is accepted. The predicted replies
    // wait in order until the block delivers its results.
    class table_scoreboard;
        logic [KEY_BITS-1:0]   keys   [CAPACITY];
        logic [VALUE_BITS-1:0] values [CAPACITY];
        int unsigned           live_count;
        reply_t                expected_replies[$];
        int unsigned           errors;

        function new();
            live_count = 0;
            errors     = 0;
        endfunction

        task report(input string what);
            errors++;
            if (errors <= PRINT_LIMIT) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
        endtask

        function int find_slot(input logic [KEY_BITS-1:0] key);
            for (int i = 0; i < live_count; i++) begin
                if (keys[i] == key) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // Apply one request to the table copy and queue the reply it causes.
        function void note_request(input logic [MODE_W-1:0] mode,
                                   input logic [KEY_BITS-1:0] key,
                                   input logic [VALUE_BITS-1:0] value);
            reply_t reply;
            int     slot;
            slot             = find_slot(key);
            reply.status     = STAT_NOT_FOUND;
            reply.read_value = '0;
            case (mode)
                MODE_INSERT: begin
                    if (slot >= 0) begin
                        values[slot] = value;
                        reply.status = STAT_UPDATED;
                    end else if (live_count >= CAPACITY) begin
                        reply.status = STAT_FULL;
                    end else begin
                        keys[live_count]   = key;
                        values[live_count] = value;
                        live_count++;
                        reply.status = STAT_INSERTED;
                    end
                end
                MODE_SEARCH: begin
                    if (slot >= 0) begin
                        reply.read_value = values[slot];
                        reply.status     = STAT_FOUND;
                    end
                end
                MODE_REMOVE: begin
                    if (slot >= 0) begin
                        for (int j = slot; j + 1 < live_count; j++) begin
                            keys[j]   = keys[j + 1];
                            values[j] = values[j + 1];
                        end
                        live_count--;
                        reply.status = STAT_REMOVED;
                    end
                end
                default: begin
                end
            endcase
            reply.entry_count = CNT_W'(live_count);
            expected_replies.push_back(reply);
        endfunction

        // Compare one delivered result with the oldest predicted reply.
        task check_reply(input logic [M_DATA_W-1:0] word);
            reply_t  want;
            status_t got_status;
            logic [VALUE_BITS-1:0] got_value;
            logic [CNT_W-1:0]      got_count;
            got_status = status_t'(word[STATUS_W-1:0]);
            got_value  = word[STATUS_W +: VALUE_BITS];
            got_count  = word[STATUS_W + VALUE_BITS +: CNT_W];
            if (expected_replies.size() == 0) begin
                report($sformatf("result with nothing pending, status %0d", got_status));
            end else begin
                want = expected_replies.pop_front();
                if (got_status !== want.status) begin
                    report($sformatf("status %0d, expected %s", got_status,
                                     want.status.name()));
                end
                if (got_value !== want.read_value) begin
                    report($sformatf("read_value %h, expected %h", got_value,
                                     want.read_value));
                end
                if (got_count !== want.entry_count) begin
                    report($sformatf("entry_count %0d, expected %0d", got_count,
                                     want.entry_count));
                end
            end
        endtask
    endclass

    // Every input starts at a known value so the block never sees X.
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // Chances, in percent, that the sender idles for a cycle before a transfer
    // and that the receiver holds off a result for a cycle.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    table_scoreboard sb = new();

    linear_key_value_table_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The result side. A transfer is taken when valid and ready were both high
    // during the cycle that this edge closes. The ready for the next cycle is
    // then drawn at random according to the current stall rate.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_reply(m_tdata);
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one request and hold it until the block takes it. The valid line is
    // only lowered while idling, so back-to-back transfers keep it high and it
    // never gets two updates in one time step.
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [KEY_BITS-1:0] key,
                                input logic [VALUE_BITS-1:0] value);
        logic [S_DATA_W-1:0] word;
        word = '0;
        word[MODE_W-1:0]                    = mode;
        word[MODE_W +: KEY_BITS]            = key;
        word[MODE_W + KEY_BITS +: VALUE_BITS] = value;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.note_request(mode, key, value);
    endtask

    // Stop sending and wait until every predicted reply has been delivered.
    // The loop waits on an edge before it checks, so the valid line is not raised
    // again in the same step in which it was lowered.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (sb.expected_replies.size() != 0);
    endtask

    // Keys are taken from the live entries with a chance of live_pct percent, so
    // that updates, hits and removes at every position happen often. The rest are
    // the extreme words or random words, which nearly always miss.
    function automatic logic [KEY_BITS-1:0] pick_key(input int unsigned live_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (sb.live_count > 0 && r < live_pct) begin
            return sb.keys[$urandom_range(sb.live_count - 1)];
        end else if (r >= 96) begin
            return (r[0]) ? '1 : '0;
        end
        return $urandom;
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3) begin
            return '0;
        end else if (r < 6) begin
            return '1;
        end
        return $urandom;
    endfunction

    // A small share of unused mode codes is kept in every mix as noise.
    function automatic logic [MODE_W-1:0] pick_mode(input int unsigned insert_pct,
                                                   input int unsigned search_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3) begin
            return MODE_UNUSED;
        end else if (r < 3 + insert_pct) begin
            return MODE_INSERT;
        end else if (r < 3 + insert_pct + search_pct) begin
            return MODE_SEARCH;
        end
        return MODE_REMOVE;
    endfunction

    task automatic random_requests(input int count, input int unsigned insert_pct,
                                   input int unsigned search_pct,
                                   input int unsigned live_pct);
        logic [MODE_W-1:0] mode;
        repeat (count) begin
            mode = pick_mode(insert_pct, search_pct);
            send_request(mode, pick_key(live_pct), pick_value());
        end
    endtask

    // Fill the table to capacity with fresh keys, with some other traffic mixed
    // in, then push a few more new keys against the full table and update a
    // live one while it is full.
    task automatic fill_to_capacity();
        while (sb.live_count < CAPACITY) begin
            if ($urandom_range(99) < 80) begin
                send_request(MODE_INSERT, $urandom, pick_value());
            end else begin
                random_requests(1, 30, 50, 70);
            end
        end
        repeat ($urandom_range(3, 8)) begin
            send_request(MODE_INSERT, pick_key(20), pick_value());
        end
        send_request(MODE_SEARCH, sb.keys[CAPACITY - 1], pick_value());
        send_request(MODE_INSERT, sb.keys[$urandom_range(CAPACITY - 1)], pick_value());
    endtask

    // One stretch of random traffic under the current idle rates: fill,
    // mixed work, then a drain that is heavy on removes.
    task automatic random_phase();
        fill_to_capacity();
        random_requests(220, 35, 35, 65);
        hold_until_drained();
        random_requests(175, 15, 30, 75);
    endtask

    initial begin
        int unsigned phase_send [3];
        int unsigned phase_recv [3];
        phase_send = '{23, 58, 0};
        phase_recv = '{58, 23, 0};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: the empty table, the extreme key and value words, every
        // mode including the unused one, update of a live key, and removes of
        // the last and the first entry.
        send_request(MODE_SEARCH, '0, '0);
        send_request(MODE_REMOVE, '1, '1);
        send_request(MODE_UNUSED, '0, '1);
        send_request(MODE_INSERT, '0, '1);
        send_request(MODE_INSERT, '1, '0);
        send_request(MODE_SEARCH, '0, '0);
        send_request(MODE_SEARCH, '1, '1);
        send_request(MODE_INSERT, '0, 32'h5A5A_A5A5);
        send_request(MODE_SEARCH, '0, '0);
        send_request(MODE_INSERT, 32'h8000_0001, 32'h7FFF_FFFE);
        send_request(MODE_UNUSED, '1, '1);
        send_request(MODE_SEARCH, 32'h8000_0001, '0);
        send_request(MODE_SEARCH, 32'h1234_5678, '0);
        send_request(MODE_REMOVE, 32'h8000_0001, '0);
        send_request(MODE_REMOVE, 32'h8000_0001, '0);
        send_request(MODE_REMOVE, '0, '0);
        send_request(MODE_SEARCH, '1, '0);
        send_request(MODE_SEARCH, '0, '0);
        send_request(MODE_REMOVE, '1, '1);
        send_request(MODE_SEARCH, '1, '0);
        hold_until_drained();

        // Random part, once with each pair of idle rates.
        for (int p = 0; p < 3; p++) begin
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            random_phase();
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.expected_replies.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Watchdog: far longer than the slowest correct run needs.
    initial begin
        #8ms;
        $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// File: linear_key_value_table_core.f
hw/rtl/lkvt_pkg.sv
hw/rtl/lkvt_ram.sv
hw/rtl/linear_key_value_table_core.sv
bench/tb.sv
